@@ hw/rtl/lubr_pkg.sv @@
// Shared types and constants for the longest unique byte run block.
package lubr_pkg;

  // Widths of the payload fields.
  localparam int CODE_W = 8;
  localparam int LEN_W  = 16;

  // Largest length the result field can carry.
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // One input byte of a string.
  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic              end_of_string;
  } item_t;

  // One result per string.
  typedef struct packed {
    logic [LEN_W-1:0] longest_length;
    logic             overflow;
  } result_t;

endpackage

@@ hw/rtl/longest_unique_byte_run_top.sv @@
// Top level of the longest unique byte run block: window tracking and result register.
// The final byte loads the result register from the compute stage once it is free.
// Throughput: one byte per cycle but for that wait, set by table RMW with forwarding.
// The next string may start right after the final byte; no gap is needed between strings.
// Reset clears the pipeline, window, position, best length and all valid bits at once.
// Table contents are left as they are; no clearing pass runs after reset.
module longest_unique_byte_run_top #(
  parameter int POS_BITS = 16,
  parameter int ALPHABET = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  lubr_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output lubr_pkg::result_t result
);
  import lubr_pkg::*;

  localparam int AW = $clog2(ALPHABET);
  localparam int WB = (POS_BITS > LEN_W) ? POS_BITS : LEN_W;
  localparam logic [AW-1:0] CODE_LAST = AW'(ALPHABET - 1);

  logic                item_accept;
  logic [AW-1:0]       code_idx;
  logic                s1_valid;
  logic                s1_last;
  logic                s1_go;
  logic                hit;
  logic [POS_BITS-1:0] look_pos;
  logic                wr_en;
  logic                clear;
  logic                at_max;
  logic [POS_BITS-1:0] window_start;
  logic [POS_BITS-1:0] position;
  logic [POS_BITS-1:0] best_length;
  logic                overflow_seen;
  logic [POS_BITS-1:0] start_c;
  logic [POS_BITS-1:0] run_c;
  logic [POS_BITS-1:0] best_c;
  logic [POS_BITS-1:0] best_fin;
  logic [WB-1:0]       best_ext;
  logic                sat;

  // Input handshake: stall only while the compute stage cannot move on.
  assign item_stall  = s1_valid && !s1_go;
  assign item_accept = item_valid && !item_stall;

  // Codes beyond the alphabet fold onto its last entry.
  assign code_idx = ({1'b0, item.char_code} >= (CODE_W + 1)'(ALPHABET)) ?
                    CODE_LAST : item.char_code[AW-1:0];

  lubr_hist #(
    .POS_BITS (POS_BITS),
    .ALPHABET (ALPHABET),
    .AW       (AW)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (item_accept),
    .rd_addr (code_idx),
    .wr_en   (wr_en),
    .wr_data (position + 1'b1),
    .clear   (clear),
    .hit     (hit),
    .pos     (look_pos)
  );

  // Compute stage holds one byte; a final byte waits for a free result register.
  assign s1_go = s1_valid && !(s1_last && result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
    if (item_accept) begin
      s1_last <= item.end_of_string;
    end
  end

  // Window arithmetic for the byte in the compute stage.
  assign at_max  = (position == '1);
  assign start_c = (hit && (look_pos > window_start)) ? look_pos : window_start;
  assign run_c   = position - start_c + 1'b1;
  assign best_c  = (run_c > best_length) ? run_c : best_length;
  assign wr_en   = s1_go && !at_max;
  assign clear   = s1_go && s1_last;

  // Per-string state: cleared after the final byte, frozen once positions run out.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      window_start  <= '0;
      position      <= '0;
      best_length   <= '0;
      overflow_seen <= 1'b0;
    end else if (s1_go) begin
      if (at_max) begin
        overflow_seen <= 1'b1;
      end else begin
        window_start <= start_c;
        position     <= position + 1'b1;
        best_length  <= best_c;
      end
    end
  end

  // Final length with saturation to the result width.
  assign best_fin = at_max ? best_length : best_c;
  assign best_ext = WB'(best_fin);
  assign sat      = best_ext > WB'(LEN_MAX);

  // Result register: loaded by a final byte, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (clear) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (clear) begin
      result.longest_length <= sat ? LEN_MAX : best_ext[LEN_W-1:0];
      result.overflow       <= overflow_seen || at_max || sat;
    end
  end

`ifndef SYNTHESIS
  // The window never starts beyond the current position.
  a_start_le_pos: assert property (@(posedge clk) disable iff (rst)
    window_start <= position)
    else $error("window start ahead of position");

  // The best run can never be longer than the bytes seen so far.
  a_best_le_pos: assert property (@(posedge clk) disable iff (rst)
    best_length <= position)
    else $error("best length exceeds position");

  // A final byte leaves clean string state and a pending result.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    clear |=> (position == '0) && (best_length == '0) && result_valid)
    else $error("string state not cleared after final byte");

  // Input is held back only while a byte sits blocked in the compute stage.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && s1_last && result_valid && result_stall))
    else $error("input stalled without cause");
`endif

endmodule

@@ hw/rtl/lubr_hist.sv @@
// Last-occurrence table: position memory, valid bits and write-to-read forwarding.
module lubr_hist #(
  parameter int POS_BITS = 16,
  parameter int ALPHABET = 256,
  parameter int AW       = 8
) (
  input  logic                clk,
  input  logic                rst,
  // Lookup issued when a byte transfer is accepted.
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  // Update for the byte held in the compute stage.
  input  logic                wr_en,
  input  logic [POS_BITS-1:0] wr_data,
  input  logic                clear,
  // Lookup result for the byte held in the compute stage.
  output logic                hit,
  output logic [POS_BITS-1:0] pos
);
  import lubr_pkg::*;

  logic [POS_BITS-1:0] mem [ALPHABET];
  logic [ALPHABET-1:0] seen_valid;
  logic [AW-1:0]       addr;
  logic [POS_BITS-1:0] rd_data;
  logic                fwd;
  logic [POS_BITS-1:0] fwd_data;

  // Synchronous read of the memory; address kept for the compute stage.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      addr    <= rd_addr;
    end
  end

  // Write back the new position of the byte in the compute stage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // A read that coincides with a write to the same entry sees the old data,
  // so the written value is captured and held along with the lookup until
  // the next read, even while the byte waits in the compute stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (rd_addr == addr);
    end
    if (rd_en) begin
      fwd_data <= wr_data;
    end
  end

  // Valid bits; the end of a string clears them all at once.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      seen_valid <= '0;
    end else if (wr_en) begin
      seen_valid[addr] <= 1'b1;
    end
  end

  assign hit = seen_valid[addr];
  assign pos = fwd ? fwd_data : rd_data;

endmodule
